/* hw/rtl/tma_pkg.sv */
package tma_pkg;

    localparam int unsigned WINDOW_REG_WIDTH = 6;
    localparam int unsigned CFG_INDEX_WIDTH  = 1;
    localparam logic [WINDOW_REG_WIDTH-1:0] WINDOW_RESET = 6'd4;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_WINDOW_WIDTH = 1'b0,
        CFG_WEIGHT_MODE  = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic start;
        logic negative;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_rsp;

endpackage

/* hw/rtl/trailing_weighted_moving_average.sv */
// From an accepted transaction to the result, the block does one history read and
// one multiply-accumulate per window sample averaged, then one quotient bit per cycle.
// It takes a new transaction only once the previous result is registered; the input
// stalls meanwhile, and longer while an earlier result is still held by a stalled receiver.
// Reset (synchronous, active low) empties the history, sets window_width to 4 and flat weights.
module trailing_weighted_moving_average #(
    parameter int unsigned MAX_WINDOW   = 32,
    parameter int unsigned SAMPLE_WIDTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]           i_sample,
    input  logic                                     i_start_of_sequence,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]           o_average,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [tma_pkg::CFG_INDEX_WIDTH-1:0]      i_cfg_index,
    input  logic [tma_pkg::WINDOW_REG_WIDTH-1:0]     i_cfg_data
);

    import tma_pkg::*;

    localparam int unsigned ADDR_W   = $clog2(MAX_WINDOW);
    localparam int unsigned CNT_W    = $clog2(MAX_WINDOW + 1);
    localparam int unsigned CMP_W    = (CNT_W > WINDOW_REG_WIDTH) ? CNT_W : WINDOW_REG_WIDTH;
    localparam int unsigned WSUM_MAX = MAX_WINDOW * (MAX_WINDOW + 1) / 2;
    localparam int unsigned WSUM_W   = $clog2(WSUM_MAX + 1);
    localparam int unsigned ACC_W    = SAMPLE_WIDTH + WSUM_W;
    localparam int unsigned PROD_W   = SAMPLE_WIDTH + CNT_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DIV,
        S_OUT
    } t_state;

    t_state                          r_state;
    logic [WINDOW_REG_WIDTH-1:0]     r_window_width;
    logic                            r_weight_mode;
    logic [CNT_W-1:0]                r_filled;
    logic [CNT_W-1:0]                r_used;
    logic [CNT_W-1:0]                r_issue;
    logic [CNT_W-1:0]                r_wt;
    logic [CNT_W-1:0]                r_s1_wt;
    logic                            r_s1_v;
    logic                            r_s2_v;
    logic [ADDR_W-1:0]               r_wr_pos;
    logic [ADDR_W-1:0]               r_rd_addr;
    logic signed [PROD_W-1:0]        r_prod;
    logic signed [ACC_W-1:0]         r_acc;
    logic [WSUM_W-1:0]               r_wsum;
    logic                            r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0]  r_average;

    logic [CMP_W-1:0]                ww_ext;
    logic [CNT_W-1:0]                w_eff;
    logic [CNT_W-1:0]                filled_next;
    logic [CNT_W-1:0]                used_next;
    logic [ADDR_W-1:0]               wr_addr;
    logic [ADDR_W-1:0]               wr_pos_next;
    logic [ADDR_W-1:0]               rd_addr_next;
    logic                            in_accept;
    logic                            issue_go;
    logic                            run_done;
    logic [ACC_W-1:0]                acc_mag;
    logic [SAMPLE_WIDTH-1:0]         hist_rdata;
    logic signed [SAMPLE_WIDTH-1:0]  div_quot;
    t_div_req                        div_req;
    t_div_rsp                        div_rsp;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign ww_ext    = CMP_W'(r_window_width);

    always_comb begin
        if (ww_ext == '0) begin
            w_eff = CNT_W'(1);
        end else if (ww_ext > CMP_W'(MAX_WINDOW)) begin
            w_eff = CNT_W'(MAX_WINDOW);
        end else begin
            w_eff = CNT_W'(ww_ext);
        end
    end

    always_comb begin
        if (i_start_of_sequence) begin
            filled_next = CNT_W'(1);
        end else if (r_filled == CNT_W'(MAX_WINDOW)) begin
            filled_next = r_filled;
        end else begin
            filled_next = r_filled + 1'b1;
        end
    end

    assign used_next    = (filled_next < w_eff) ? filled_next : w_eff;
    assign wr_addr      = i_start_of_sequence ? '0 : r_wr_pos;
    assign wr_pos_next  = (wr_addr == ADDR_W'(MAX_WINDOW - 1)) ? '0 : wr_addr + 1'b1;
    assign rd_addr_next = (r_rd_addr == '0) ? ADDR_W'(MAX_WINDOW - 1) : r_rd_addr - 1'b1;

    assign issue_go = (r_state == S_RUN) && (r_issue != r_used);
    assign run_done = (r_state == S_RUN) && !issue_go && !r_s1_v && !r_s2_v;

    assign div_req.start    = run_done;
    assign div_req.negative = r_acc[ACC_W-1];
    assign acc_mag          = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);

    tma_history #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (SAMPLE_WIDTH)
    ) u_history (
        .i_clk     (i_clk),
        .i_wr_en   (in_accept),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_sample),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (hist_rdata)
    );

    tma_divider #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .WSUM_WIDTH   (WSUM_W)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_mag   (acc_mag),
        .i_den   (r_wsum),
        .o_rsp   (div_rsp),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_window_width <= WINDOW_RESET;
            r_weight_mode  <= 1'b0;
            r_filled       <= '0;
            r_wr_pos       <= '0;
            r_used         <= '0;
            r_issue        <= '0;
            r_s1_v         <= 1'b0;
            r_s2_v         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_WINDOW_WIDTH: r_window_width <= i_cfg_data;
                    CFG_WEIGHT_MODE:  r_weight_mode  <= i_cfg_data[0];
                endcase
            end

            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            r_s1_v  <= issue_go;
            r_s1_wt <= r_wt;
            r_s2_v  <= r_s1_v;
            r_prod  <= $signed(hist_rdata) * $signed({1'b0, r_s1_wt});
            if (r_s2_v) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_wr_pos  <= wr_pos_next;
                        r_filled  <= filled_next;
                        r_used    <= used_next;
                        r_issue   <= '0;
                        r_rd_addr <= wr_addr;
                        r_wt      <= r_weight_mode ? w_eff : CNT_W'(1);
                        r_acc     <= '0;
                        r_wsum    <= '0;
                        r_state   <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (issue_go) begin
                        r_issue   <= r_issue + 1'b1;
                        r_rd_addr <= rd_addr_next;
                        r_wsum    <= r_wsum + WSUM_W'(r_wt);
                        if (r_weight_mode) begin
                            r_wt <= r_wt - 1'b1;
                        end
                    end else if (run_done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_average   <= div_quot;
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_average   = r_average;
    assign o_cfg_ready = 1'b1;

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue <= r_used)
        else $error("more history reads issued than samples in the window");

    a_filled_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= CNT_W'(MAX_WINDOW))
        else $error("fill count exceeds the history depth");

    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_rsp.busy || div_rsp.done) |-> (r_state == S_DIV))
        else $error("divider active outside the divide state");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> (r_wsum != '0))
        else $error("division started with a zero weight sum");

endmodule

/* hw/rtl/tma_history.sv */
module tma_history #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/tma_divider.sv */
module tma_divider #(
    parameter int unsigned SAMPLE_WIDTH = 16,
    parameter int unsigned WSUM_WIDTH   = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tma_pkg::t_div_req                   i_req,
    input  logic [SAMPLE_WIDTH+WSUM_WIDTH-1:0]  i_mag,
    input  logic [WSUM_WIDTH-1:0]               i_den,
    output tma_pkg::t_div_rsp                   o_rsp,
    output logic signed [SAMPLE_WIDTH-1:0]      o_quot
);

    import tma_pkg::*;

    localparam int unsigned MAG_W  = SAMPLE_WIDTH + WSUM_WIDTH;
    localparam int unsigned DIV_W  = MAG_W + 2;
    localparam int unsigned STEP_W = $clog2(SAMPLE_WIDTH + 1);

    logic [DIV_W-1:0]        r_rem;
    logic [DIV_W-1:0]        r_dvs;
    logic [SAMPLE_WIDTH-1:0] r_quot;
    logic                    r_neg;
    logic                    r_busy;
    logic                    r_done;
    logic [STEP_W-1:0]       r_step;
    logic                    ge;

    assign ge = (r_rem >= r_dvs);

    // Rounded quotient (2*mag + den) / (2*den), one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= {1'b0, i_mag, 1'b0} + DIV_W'(i_den);
                r_dvs  <= DIV_W'(i_den) << SAMPLE_WIDTH;
                r_neg  <= i_req.negative;
                r_quot <= '0;
                r_busy <= 1'b1;
                r_step <= STEP_W'(SAMPLE_WIDTH);
            end else if (r_busy) begin
                if (ge) begin
                    r_rem <= r_rem - r_dvs;
                end
                r_quot <= {r_quot[SAMPLE_WIDTH-2:0], ge};
                r_dvs  <= r_dvs >> 1;
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_quot     = r_neg ? $signed(-r_quot) : $signed(r_quot);

endmodule

/* tb/trailing_weighted_moving_average_tb.sv */
module trailing_weighted_moving_average_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tma_pkg::*;

    localparam int unsigned DEPTH = 32;
    localparam int unsigned SAMPLE_BITS = 16;
    localparam int unsigned SETTLE_CYCLES = 60;
    localparam int unsigned SEGMENTS = 12;
    localparam int unsigned SEGMENT_ITEMS = 134;

    class average_scoreboard;
        logic signed [SAMPLE_BITS-1:0] history [DEPTH];
        int unsigned filled_count;
        int unsigned write_pos;
        logic [WINDOW_REG_WIDTH-1:0] window_width;
        logic weight_mode;
        logic signed [SAMPLE_BITS-1:0] expected_averages [$];
        int failures;

        function new();
            foreach (history[i]) history[i] = '0;
            filled_count = 0;
            write_pos = 0;
            window_width = WINDOW_RESET;
            weight_mode = 1'b0;
            failures = 0;
        endfunction

        function void set_register(t_cfg_index index, logic [WINDOW_REG_WIDTH-1:0] data);
            case (index)
                CFG_WINDOW_WIDTH: window_width = data;
                CFG_WEIGHT_MODE: weight_mode = data[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_averages.size();
        endfunction

        function void add_sample(logic signed [SAMPLE_BITS-1:0] value, logic series_start);
            int unsigned width;
            int unsigned used;
            int unsigned newest;
            int unsigned slot;
            longint total;
            longint weight_sum;
            longint weight;
            longint magnitude;
            longint rounded;
            if (series_start) begin
                filled_count = 0;
                write_pos = 0;
            end
            history[write_pos] = value;
            newest = write_pos;
            write_pos = (write_pos + 1) % DEPTH;
            if (filled_count < DEPTH) filled_count++;
            width = window_width;
            if (width < 1) width = 1;
            if (width > DEPTH) width = DEPTH;
            used = (filled_count < width) ? filled_count : width;
            total = 0;
            weight_sum = 0;
            for (int age = 0; age < used; age++) begin
                slot = (newest + DEPTH - age) % DEPTH;
                weight = weight_mode ? longint'(width - age) : 64'sd1;
                total += weight * longint'(history[slot]);
                weight_sum += weight;
            end
            magnitude = (total < 0) ? -total : total;
            rounded = (2 * magnitude + weight_sum) / (2 * weight_sum);
            if (total < 0) rounded = -rounded;
            expected_averages.push_back(SAMPLE_BITS'(rounded));
        endfunction

        function void compare_average(logic signed [SAMPLE_BITS-1:0] actual);
            logic signed [SAMPLE_BITS-1:0] expected;
            if (expected_averages.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected average %0d at %0t", actual, $realtime);
                return;
            end
            expected = expected_averages.pop_front();
            if (actual !== expected) begin
                failures++;
                if (failures <= 10)
                    $display("average mismatch at %0t: expected %0d, actual %0d",
                             $realtime, expected, actual);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [SAMPLE_BITS-1:0] i_sample = '0;
    logic i_start_of_sequence = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_average;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index = '0;
    logic [WINDOW_REG_WIDTH-1:0] i_cfg_data = '0;

    average_scoreboard scoreboard = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_burst_request = 0;
    int stall_burst_left = 0;

    int unsigned segment_width [SEGMENTS] = '{1, 32, 0, 63, 33, 5, 32, 1, 17, 4, 2, 31};
    logic segment_mode [SEGMENTS] = '{0, 1, 1, 0, 1, 0, 0, 1, 1, 0, 1, 1};

    trailing_weighted_moving_average #(
        .MAX_WINDOW(DEPTH),
        .SAMPLE_WIDTH(SAMPLE_BITS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_sample(i_sample),
        .i_start_of_sequence(i_start_of_sequence),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_average(o_average),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // A long stall burst lets the block fill up and hold off new transactions.
    always @(posedge i_clk) begin
        if (stall_burst_request > 0) begin
            stall_burst_left = stall_burst_request;
            stall_burst_request = 0;
        end
        if (stall_burst_left > 0) begin
            i_out_stall <= 1'b1;
            stall_burst_left--;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            scoreboard.compare_average(o_average);
    end

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic series_start);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample <= value;
        i_start_of_sequence <= series_start;
        do @(posedge i_clk); while (o_in_stall);
        scoreboard.add_sample(value, series_start);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (scoreboard.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_window(input logic [WINDOW_REG_WIDTH-1:0] width, input logic mode);
        t_cfg_index index [2];
        logic [WINDOW_REG_WIDTH-1:0] data [2];
        index[0] = CFG_WINDOW_WIDTH;
        index[1] = CFG_WEIGHT_MODE;
        data[0] = width;
        data[1] = {5'($urandom_range(0, 31)), mode};
        for (int k = 0; k < 2; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= index[k];
            i_cfg_data <= data[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            scoreboard.set_register(index[k], data[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 3))
            0: return SAMPLE_BITS'($urandom);
            1: return SAMPLE_BITS'(int'($urandom_range(0, 16)) - 8);
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return $urandom_range(0, 1) ? SAMPLE_BITS'(32767 - int'($urandom_range(0, 3)))
                                                 : SAMPLE_BITS'(-32768 + int'($urandom_range(0, 3)));
        endcase
    endfunction

    initial begin
        #5_000_000;
        $display("trailing_weighted_moving_average_tb failed");
        $finish;
    end

    initial begin
        bit short_series;
        send_idle_pct = 34;
        recv_idle_pct = 68;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset window of four with flat weights; the first series starts unflagged.
        send_sample(1, 1'b0);
        send_sample(2, 1'b0);
        send_sample(-32768, 1'b1);
        send_sample(-32767, 1'b0);
        send_sample(32767, 1'b1);
        repeat (4) send_sample(32767, 1'b0);
        send_sample(-1, 1'b1);
        send_sample(-2, 1'b0);
        send_sample(0, 1'b0);
        send_sample(3, 1'b0);
        drain();
        set_window(6'd32, 1'b1);
        send_sample(-32768, 1'b1);
        send_sample(32767, 1'b0);
        send_sample(32767, 1'b0);
        send_sample(-32768, 1'b0);
        send_sample(-32767, 1'b0);
        send_sample(5, 1'b1);
        send_sample(-5, 1'b0);
        drain();
        set_window(6'd0, 1'b0);
        send_sample(12345, 1'b0);
        send_sample(-12345, 1'b1);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg / 4)
                0: begin send_idle_pct = 34; recv_idle_pct = 68; end
                1: begin send_idle_pct = 68; recv_idle_pct = 34; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            drain();
            set_window(WINDOW_REG_WIDTH'(segment_width[seg]), segment_mode[seg]);
            short_series = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < SEGMENT_ITEMS; n++) begin
                if (seg == 9 && n == 20) stall_burst_request = 400;
                send_sample(pick_sample(),
                            ($urandom_range(0, 39) == 0) ||
                            (short_series && $urandom_range(0, 3) == 0));
            end
        end
        drain();

        if (scoreboard.failures == 0 && scoreboard.pending() == 0) begin
            $display("trailing_weighted_moving_average_tb passed");
        end else begin
            $display("trailing_weighted_moving_average_tb failed");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/tma_pkg.sv
hw/rtl/tma_history.sv
hw/rtl/tma_divider.sv
hw/rtl/trailing_weighted_moving_average.sv
tb/trailing_weighted_moving_average_tb.sv
